// ===== rtl/click_gate_occupancy_controller_unit_assert.svh =====
// Assertion macros for the click gate occupancy controller.
// Expects clk and arst_n in the including scope; no other dependencies.
`ifndef CLICK_GATE_OCCUPANCY_CONTROLLER_UNIT_ASSERT_SVH
`define CLICK_GATE_OCCUPANCY_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define CGOC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cgoc assertion failed");

// next-cycle implication
`define CGOC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cgoc assertion failed");

`endif

// ===== rtl/cgoc_pkg.sv =====
// Package for the click gate occupancy controller: payload and config types,
// register indexes and reset constants. No dependencies.
package cgoc_pkg;

	localparam int unsigned CAPACITY_DEF = 4;
	localparam int unsigned CFG_IDX_W    = 2;
	localparam int unsigned CFG_DATA_W   = 16;

	localparam logic [15:0] CLICK_WINDOW_RST  = 16'd500;
	localparam logic [15:0] OPEN_DURATION_RST = 16'd1500;
	localparam logic [11:0] OPEN_PULSE_RST    = 12'd788;
	localparam logic [11:0] CLOSED_PULSE_RST  = 12'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLICK_WINDOW  = 2'd0,
		REG_OPEN_DURATION = 2'd1,
		REG_OPEN_PULSE    = 2'd2,
		REG_CLOSED_PULSE  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic        button_level;
		logic [31:0] now;
	} poll_t;

	typedef struct packed {
		logic        gate_open;
		logic [11:0] servo_pulse;
		logic [3:0]  free_places;
		logic        count_changed;
	} result_t;

	typedef struct packed {
		logic [15:0] click_window;
		logic [15:0] open_duration;
		logic [11:0] open_pulse;
		logic [11:0] closed_pulse;
	} cfg_t;

	// signed elapsed time strictly above limit
	function automatic logic elapsed_over(logic [31:0] now, logic [31:0] stamp,
			logic [15:0] limit);
		logic [31:0] d;
		d = now - stamp;
		return !d[31] && (d > {16'd0, limit});
	endfunction

endpackage

// ===== rtl/click_gate_occupancy_controller_unit.sv =====
// Top level of the click gate occupancy controller: poll register, state
// update and result register. Depends on cgoc_pkg, cgoc_cfg_regs, cgoc_step and the assertion header.
//
//   channel  | signals                          | accepted when
//   ---------+----------------------------------+------------------------------
//   poll     | poll_valid, poll_stall, poll     | poll_valid && !poll_stall
//   result   | result_valid, result_stall, result | result_valid && !result_stall
//   config   | cfg_wr_en, cfg_index, cfg_wdata  | cfg_wr_en
//
// One transaction per cycle while the result is not stalled; a poll passes through the
// poll register, then the state update into the result register.
// Reset restores register defaults, closes the gate, fills all free places.
// A stalled result holds; poll_stall rises only when both registers are full.
module click_gate_occupancy_controller_unit #(
	parameter int unsigned CAPACITY = cgoc_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            poll_valid,
	output logic                            poll_stall,
	input  cgoc_pkg::poll_t                 poll,
	output logic                            result_valid,
	input  logic                            result_stall,
	output cgoc_pkg::result_t               result,
	input  logic                            cfg_wr_en,
	input  logic [cgoc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cgoc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	cgoc_pkg::cfg_t    cfg;
	cgoc_pkg::poll_t   poll_s1;
	cgoc_pkg::result_t result_d, result_q;
	logic              valid_s1, result_valid_q;
	logic              adv, fire;

	cgoc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign adv        = !result_valid_q || !result_stall;
	assign fire       = valid_s1 && adv;
	assign poll_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!poll_stall) begin
			valid_s1 <= poll_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll_valid && !poll_stall) begin
			poll_s1 <= poll;
		end
	end

	cgoc_step #(.CAPACITY(CAPACITY)) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.poll   (poll_s1),
		.cfg    (cfg),
		.result (result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`include "click_gate_occupancy_controller_unit_assert.svh"

	`CGOC_ASSERT_IMP(a_change_opens, result_valid && result.count_changed, result.gate_open)
	`CGOC_ASSERT_IMP(a_count_in_range, result_valid, result.free_places <= 4'(CAPACITY))
	`CGOC_ASSERT_NXT(a_drain_empties, result_valid && !result_stall && !valid_s1,
		!result_valid)
	`CGOC_ASSERT_IMP(a_stall_needs_full, poll_stall, result_valid && valid_s1)

endmodule

// ===== rtl/cgoc_cfg_regs.sv =====
// Configuration register file for the click gate occupancy controller.
// Depends on cgoc_pkg.
module cgoc_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_wr_en,
	input  logic [cgoc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cgoc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output cgoc_pkg::cfg_t                       cfg
);

	cgoc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.click_window  <= cgoc_pkg::CLICK_WINDOW_RST;
			cfg_q.open_duration <= cgoc_pkg::OPEN_DURATION_RST;
			cfg_q.open_pulse    <= cgoc_pkg::OPEN_PULSE_RST;
			cfg_q.closed_pulse  <= cgoc_pkg::CLOSED_PULSE_RST;
		end else if (cfg_wr_en) begin
			case (cgoc_pkg::reg_idx_t'(cfg_index))
				cgoc_pkg::REG_CLICK_WINDOW:  cfg_q.click_window  <= cfg_wdata;
				cgoc_pkg::REG_OPEN_DURATION: cfg_q.open_duration <= cfg_wdata;
				cgoc_pkg::REG_OPEN_PULSE:    cfg_q.open_pulse    <= cfg_wdata[11:0];
				cgoc_pkg::REG_CLOSED_PULSE:  cfg_q.closed_pulse  <= cfg_wdata[11:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/cgoc_step.sv =====
// Gate state and per-poll update logic; produces the result of one poll.
// Depends on cgoc_pkg.
module cgoc_step #(
	parameter int unsigned CAPACITY = cgoc_pkg::CAPACITY_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  cgoc_pkg::poll_t   poll,
	input  cgoc_pkg::cfg_t    cfg,
	output cgoc_pkg::result_t result
);

	localparam logic [3:0] CAP = 4'(CAPACITY);

	logic        prev_q, pending_q, gate_q;
	logic [31:0] click_stamp_q, open_stamp_q;
	logic [3:0]  free_q;

	logic        prev_d, pending_d, gate_d, changed;
	logic [31:0] click_stamp_d, open_stamp_d;
	logic [3:0]  free_d;
	logic        clicked;

	always_comb begin
		prev_d        = prev_q;
		pending_d     = pending_q;
		gate_d        = gate_q;
		click_stamp_d = click_stamp_q;
		open_stamp_d  = open_stamp_q;
		free_d        = free_q;
		changed       = 1'b0;
		clicked       = !poll.button_level && prev_q;
		if (!gate_q) begin
			prev_d = poll.button_level;
			if (clicked) begin
				if (!pending_q) begin
					pending_d     = 1'b1;
					click_stamp_d = poll.now;
				end else begin
					if (free_q < CAP) begin
						gate_d       = 1'b1;
						open_stamp_d = poll.now;
						free_d       = free_q + 4'd1;
						changed      = 1'b1;
					end
					pending_d = 1'b0;
				end
			end else if (pending_q &&
					cgoc_pkg::elapsed_over(poll.now, click_stamp_q, cfg.click_window)) begin
				if (free_q != 4'd0) begin
					gate_d       = 1'b1;
					open_stamp_d = poll.now;
					free_d       = free_q - 4'd1;
					changed      = 1'b1;
				end
				pending_d = 1'b0;
			end
		end else if (cgoc_pkg::elapsed_over(poll.now, open_stamp_q, cfg.open_duration)) begin
			gate_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= 1'b0;
			pending_q     <= 1'b0;
			gate_q        <= 1'b0;
			click_stamp_q <= '0;
			open_stamp_q  <= '0;
			free_q        <= CAP;
		end else if (fire) begin
			prev_q        <= prev_d;
			pending_q     <= pending_d;
			gate_q        <= gate_d;
			click_stamp_q <= click_stamp_d;
			open_stamp_q  <= open_stamp_d;
			free_q        <= free_d;
		end
	end

	assign result.gate_open     = gate_d;
	assign result.servo_pulse   = gate_d ? cfg.open_pulse : cfg.closed_pulse;
	assign result.free_places   = free_d;
	assign result.count_changed = changed;

endmodule
